// File: hdl/rrf_pkg.sv
// ----------------------------------------------------------------------------
// rrf_pkg
// Shared types and constants for the run-length to rectangle fill core.
// ----------------------------------------------------------------------------
package rrf_pkg;

  // Field widths
  localparam int unsigned XW     = 10;  // column
  localparam int unsigned YW     = 11;  // row
  localparam int unsigned COLW   = 16;  // RGB565 color
  localparam int unsigned RUNW   = 16;  // run length
  localparam int unsigned WIDW   = 11;  // line width register
  localparam int unsigned ORGW   = 10;  // row origin register
  localparam int unsigned CFG_AW = 1;   // config register index
  localparam int unsigned CFG_DW = 11;  // config write data

  // Register defaults and limits
  localparam logic [WIDW-1:0] DEFAULT_WIDTH = WIDW'(480);
  localparam logic [WIDW-1:0] MAX_WIDTH     = WIDW'(1024);
  localparam logic [YW-1:0]   MAX_ROW       = YW'(2047);

  // Config register indexes
  localparam logic [CFG_AW-1:0] CFG_LINE_WIDTH = 1'b0;
  localparam logic [CFG_AW-1:0] CFG_ROW_ORIGIN = 1'b1;

  // Rectangle slot within one run
  localparam logic [1:0] RECT_FIRST  = 2'd0;
  localparam logic [1:0] RECT_SECOND = 2'd1;
  localparam logic [1:0] RECT_THIRD  = 2'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } rrf_state_e;

  // Divider control toward the divider
  typedef struct packed {
    logic            start;
    logic [WIDW-1:0] divisor;
  } rrf_div_ctl_t;

endpackage

// File: hdl/rrf_div.sv
// ----------------------------------------------------------------------------
// rrf_div
// Radix-2 restoring divider: one quotient bit per cycle, shared compare and
// subtract. Divisor is at most 1024, so the remainder fits one column field.
// ----------------------------------------------------------------------------
module rrf_div #(
  parameter int unsigned COUNT_BITS = 22
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rrf_pkg::rrf_div_ctl_t     ctl_i,
  input  logic [COUNT_BITS-1:0]     dividend_i,
  output logic                      done_o,
  output logic [COUNT_BITS-1:0]     quotient_o,
  output logic [rrf_pkg::XW-1:0]    remainder_o
);

  localparam int unsigned CNTW = $clog2(COUNT_BITS + 1);

  logic [CNTW-1:0]             cnt_q, cnt_d;
  logic                        done_q, done_d;
  logic [COUNT_BITS-1:0]       quo_q, quo_d;
  logic [rrf_pkg::XW-1:0]      rem_q, rem_d;
  logic [rrf_pkg::WIDW-1:0]    div_q, div_d;
  logic [rrf_pkg::WIDW-1:0]    trial;
  logic                        fits;
  logic [rrf_pkg::WIDW-1:0]    diff;

  // Shared compare / subtract step
  assign trial = {rem_q, quo_q[COUNT_BITS-1]};
  assign fits  = (trial >= div_q);
  assign diff  = trial - div_q;

  // Step sequencing
  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (ctl_i.start) begin
      cnt_d = CNTW'(COUNT_BITS);
      quo_d = dividend_i;
      rem_d = '0;
      div_d = ctl_i.divisor;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - CNTW'(1);
      done_d = (cnt_q == CNTW'(1));
      quo_d  = {quo_q[COUNT_BITS-2:0], fits};
      rem_d  = fits ? diff[rrf_pkg::XW-1:0] : trial[rrf_pkg::XW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// File: hdl/rle_run_to_rect_fill_core.sv
// ----------------------------------------------------------------------------
// rle_run_to_rect_fill_core
// Each run record (color, pixel count) advances a running pixel total; the
// end point is column = total mod line_width, row = total div line_width +
// row_origin (saturated at 2047), and one to three inclusive fill rectangles
// from the previous end point are produced. A run first passes through the
// shared radix-2 divider stage, then the rectangles are emitted one per cycle
// while the output side takes them. The input stalls for the whole run;
// the last rectangle may still wait in the output register while the next
// run is taken.
// ----------------------------------------------------------------------------
module rle_run_to_rect_fill_core #(
  parameter int unsigned COUNT_BITS = 22
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [rrf_pkg::CFG_AW-1:0]    cfg_idx_i,
  input  logic [rrf_pkg::CFG_DW-1:0]    cfg_wdata_i,
  // run input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          first_run_i,
  input  logic [rrf_pkg::COLW-1:0]      color_i,
  input  logic [rrf_pkg::RUNW-1:0]      run_length_i,
  // rectangle output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rrf_pkg::XW-1:0]        x_start_o,
  output logic [rrf_pkg::YW-1:0]        y_start_o,
  output logic [rrf_pkg::XW-1:0]        x_end_o,
  output logic [rrf_pkg::YW-1:0]        y_end_o,
  output logic [rrf_pkg::COLW-1:0]      fill_color_o,
  output logic                          last_rect_o
);

  // Config registers
  logic [rrf_pkg::WIDW-1:0] line_width_q;
  logic [rrf_pkg::ORGW-1:0] row_origin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= rrf_pkg::DEFAULT_WIDTH;
      row_origin_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rrf_pkg::CFG_LINE_WIDTH: line_width_q <= cfg_wdata_i[rrf_pkg::WIDW-1:0];
        rrf_pkg::CFG_ROW_ORIGIN: row_origin_q <= cfg_wdata_i[rrf_pkg::ORGW-1:0];
        default: ;
      endcase
    end
  end

  // State
  rrf_pkg::rrf_state_e state_q, state_d;
  logic [COUNT_BITS-1:0]    total_q, total_d;
  logic [rrf_pkg::XW-1:0]   prev_col_q, prev_col_d;
  logic [rrf_pkg::YW-1:0]   prev_row_q, prev_row_d;
  logic [rrf_pkg::COLW-1:0] color_q, color_d;
  logic [rrf_pkg::WIDW-1:0] w_q, w_d;
  logic [rrf_pkg::XW-1:0]   col_q, col_d;
  logic [rrf_pkg::YW-1:0]   row_q, row_d;
  logic [1:0]               rect_idx_q, rect_idx_d;

  logic                     in_accept;
  logic                     load;
  logic                     rect_last;
  logic [COUNT_BITS-1:0]    total_base;
  logic [rrf_pkg::WIDW-1:0] w_eff;

  // Divider interface
  rrf_pkg::rrf_div_ctl_t    div_ctl;
  logic                     div_done;
  logic [COUNT_BITS-1:0]    div_quo;
  logic [rrf_pkg::XW-1:0]   div_rem;

  // Row from quotient: add origin, saturate
  logic                     quo_hi;
  logic [rrf_pkg::YW:0]     row_sum;
  logic [rrf_pkg::YW-1:0]   row_sat;

  // Rectangle selection
  logic [rrf_pkg::YW:0]     pr_inc;
  logic [rrf_pkg::YW:0]     row_ext;
  logic                     row_gt;
  logic                     row_eq;
  logic [rrf_pkg::WIDW-1:0] w_m1;
  logic [rrf_pkg::YW-1:0]   row_m1;
  logic [rrf_pkg::XW-1:0]   rx_s, rx_e;
  logic [rrf_pkg::YW-1:0]   ry_s, ry_e;

  // Output register
  logic                     out_valid_q, out_valid_d;
  logic [rrf_pkg::XW-1:0]   x_start_q, x_end_q;
  logic [rrf_pkg::YW-1:0]   y_start_q, y_end_q;
  logic [rrf_pkg::COLW-1:0] fill_color_q;
  logic                     last_rect_q;

  assign in_stall_o = (state_q != rrf_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Effective width: zero acts as one, above 1024 clamps
  always_comb begin
    if (line_width_q == '0) begin
      w_eff = rrf_pkg::WIDW'(1);
    end else if (line_width_q > rrf_pkg::MAX_WIDTH) begin
      w_eff = rrf_pkg::MAX_WIDTH;
    end else begin
      w_eff = line_width_q;
    end
  end

  // Running total, wraps at COUNT_BITS
  assign total_base = first_run_i ? '0 : total_q;

  assign div_ctl.start   = in_accept;
  assign div_ctl.divisor = w_eff;

  rrf_div #(
    .COUNT_BITS (COUNT_BITS)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (div_ctl),
    .dividend_i  (total_d),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  assign quo_hi  = |div_quo[COUNT_BITS-1:rrf_pkg::YW];
  assign row_sum = {1'b0, div_quo[rrf_pkg::YW-1:0]} + (rrf_pkg::YW+1)'(row_origin_q);
  assign row_sat = (quo_hi || row_sum[rrf_pkg::YW]) ? rrf_pkg::MAX_ROW
                                                      : row_sum[rrf_pkg::YW-1:0];

  // Rectangle fields for the current slot
  assign pr_inc  = {1'b0, prev_row_q} + (rrf_pkg::YW+1)'(1);
  assign row_ext = {1'b0, row_q};
  assign row_gt  = (row_ext > pr_inc);
  assign row_eq  = (row_ext == pr_inc);
  assign w_m1    = w_q - rrf_pkg::WIDW'(1);
  assign row_m1  = row_q - rrf_pkg::YW'(1);

  always_comb begin
    rx_s      = prev_col_q;
    ry_s      = prev_row_q;
    rx_e      = col_q;
    ry_e      = row_q;
    rect_last = 1'b1;
    case (rect_idx_q)
      rrf_pkg::RECT_FIRST: begin
        if (row_gt) begin
          rx_e      = w_m1[rrf_pkg::XW-1:0];
          ry_e      = prev_row_q;
          rect_last = 1'b0;
        end else if (row_eq) begin
          rx_e      = w_m1[rrf_pkg::XW-1:0];
          ry_e      = row_m1;
          rect_last = 1'b0;
        end
      end
      rrf_pkg::RECT_SECOND: begin
        rx_s = '0;
        if (row_gt) begin
          ry_s      = pr_inc[rrf_pkg::YW-1:0];
          rx_e      = w_m1[rrf_pkg::XW-1:0];
          ry_e      = row_m1;
          rect_last = 1'b0;
        end else begin
          ry_s = row_q;
        end
      end
      rrf_pkg::RECT_THIRD: begin
        rx_s = '0;
        ry_s = row_q;
      end
      default: ;
    endcase
  end

  assign load = (state_q == rrf_pkg::ST_EMIT) && (!out_valid_q || !out_stall_i);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rrf_pkg::ST_IDLE: if (in_accept) state_d = rrf_pkg::ST_DIV;
      rrf_pkg::ST_DIV:  if (div_done)  state_d = rrf_pkg::ST_EMIT;
      rrf_pkg::ST_EMIT: if (load && rect_last) state_d = rrf_pkg::ST_IDLE;
      default:          state_d = rrf_pkg::ST_IDLE;
    endcase
  end

  // Datapath updates
  always_comb begin
    total_d     = total_q;
    prev_col_d  = prev_col_q;
    prev_row_d  = prev_row_q;
    color_d     = color_q;
    w_d         = w_q;
    col_d       = col_q;
    row_d       = row_q;
    rect_idx_d  = rect_idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      rrf_pkg::ST_IDLE: begin
        if (in_accept) begin
          total_d = total_base + COUNT_BITS'(run_length_i);
          color_d = color_i;
          w_d     = w_eff;
          if (first_run_i) begin
            prev_col_d = '0;
            prev_row_d = '0;
          end
        end
      end
      rrf_pkg::ST_DIV: begin
        if (div_done) begin
          col_d      = div_rem;
          row_d      = row_sat;
          rect_idx_d = rrf_pkg::RECT_FIRST;
        end
      end
      rrf_pkg::ST_EMIT: begin
        if (load) begin
          out_valid_d = 1'b1;
          rect_idx_d  = rect_idx_q + 2'd1;
          if (rect_last) begin
            prev_col_d = col_q;
            prev_row_d = row_q;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rrf_pkg::ST_IDLE;
      total_q     <= '0;
      prev_col_q  <= '0;
      prev_row_q  <= '0;
      rect_idx_q  <= rrf_pkg::RECT_FIRST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      prev_col_q  <= prev_col_d;
      prev_row_q  <= prev_row_d;
      rect_idx_q  <= rect_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    color_q <= color_d;
    w_q     <= w_d;
    col_q   <= col_d;
    row_q   <= row_d;
    if (load) begin
      x_start_q    <= rx_s;
      y_start_q    <= ry_s;
      x_end_q      <= rx_e;
      y_end_q      <= ry_e;
      fill_color_q <= color_q;
      last_rect_q  <= rect_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign x_start_o    = x_start_q;
  assign y_start_o    = y_start_q;
  assign x_end_o      = x_end_q;
  assign y_end_o      = y_end_q;
  assign fill_color_o = fill_color_q;
  assign last_rect_o  = last_rect_q;

  // Checks
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == rrf_pkg::ST_DIV))
    else $error("divider finished outside the divide state");

  a_accept_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == rrf_pkg::ST_DIV))
    else $error("accepted run did not enter the divide state");

  a_third_needs_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rrf_pkg::ST_EMIT && rect_idx_q == rrf_pkg::RECT_THIRD) |-> row_gt)
    else $error("third rectangle without whole middle rows");

  a_prev_follows_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && rect_last) |=> (prev_row_q == $past(row_q) && prev_col_q == $past(col_q)))
    else $error("previous point not updated after final rectangle");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rle_run_to_rect_fill_core. Run records go in through
// a bursty driver, fill rectangles are collected by a monitor while the output
// stalls on a pattern of its own, and each rectangle is checked against a
// local model of the pixel total, end point and rectangle split. Line width
// and row origin are rewritten between idle phases, covering their extremes.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned COUNT_BITS   = 22;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef struct packed {
    logic                     first;
    logic [rrf_pkg::COLW-1:0] color;
    logic [rrf_pkg::RUNW-1:0] run_len;
  } run_t;

  typedef struct packed {
    logic [rrf_pkg::XW-1:0]   x_start;
    logic [rrf_pkg::YW-1:0]   y_start;
    logic [rrf_pkg::XW-1:0]   x_end;
    logic [rrf_pkg::YW-1:0]   y_end;
    logic [rrf_pkg::COLW-1:0] fill_color;
    logic                     last_rect;
  } rect_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY
  } stall_mode_e;

  // Clock, reset and block ports
  logic                       clk         = 1'b0;
  logic                       rst_n       = 1'b0;
  logic                       cfg_we      = 1'b0;
  logic [rrf_pkg::CFG_AW-1:0] cfg_idx     = '0;
  logic [rrf_pkg::CFG_DW-1:0] cfg_wdata   = '0;
  logic                       in_valid    = 1'b0;
  logic                       in_stall;
  logic                       first_run   = 1'b0;
  logic [rrf_pkg::COLW-1:0]   color       = '0;
  logic [rrf_pkg::RUNW-1:0]   run_length  = '0;
  logic                       out_valid;
  logic                       out_stall   = 1'b0;
  logic [rrf_pkg::XW-1:0]     x_start;
  logic [rrf_pkg::YW-1:0]     y_start;
  logic [rrf_pkg::XW-1:0]     x_end;
  logic [rrf_pkg::YW-1:0]     y_end;
  logic [rrf_pkg::COLW-1:0]   fill_color;
  logic                       last_rect;

  // Model state and configuration
  logic [COUNT_BITS-1:0]    pix_total    = '0;
  logic [rrf_pkg::XW-1:0]   prev_col     = '0;
  logic [rrf_pkg::YW-1:0]   prev_row     = '0;
  logic [rrf_pkg::WIDW-1:0] model_width  = rrf_pkg::DEFAULT_WIDTH;
  logic [rrf_pkg::ORGW-1:0] model_origin = '0;

  // Queues and bookkeeping
  run_t        run_queue[$];
  rect_t       pending_rects[$];
  run_t        drive_item;
  rect_t       seen_rect;
  rect_t       want_rect;
  logic        in_fire     = 1'b0;
  int          runs_queued = 0;
  int          runs_taken  = 0;
  int          rects_seen  = 0;
  int          error_count = 0;
  int          gap_left    = 0;
  int          burst_left  = 0;
  int          hold_left   = 0;
  bit          hold_done   = 1'b0;
  int          mode_left   = 0;
  stall_mode_e stall_mode  = STALL_NONE;

  rle_run_to_rect_fill_core #(
    .COUNT_BITS (COUNT_BITS)
  ) DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .first_run_i  (first_run),
    .color_i      (color),
    .run_length_i (run_length),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .x_start_o    (x_start),
    .y_start_o    (y_start),
    .x_end_o      (x_end),
    .y_end_o      (y_end),
    .fill_color_o (fill_color),
    .last_rect_o  (last_rect)
  );

  always #10 clk = ~clk;

  function automatic rect_t make_rect(input int unsigned xs, input int unsigned ys,
                                      input int unsigned xe, input int unsigned ye,
                                      input logic [rrf_pkg::COLW-1:0] c,
                                      input logic last);
    rect_t r;
    r.x_start    = rrf_pkg::XW'(xs);
    r.y_start    = rrf_pkg::YW'(ys);
    r.x_end      = rrf_pkg::XW'(xe);
    r.y_end      = rrf_pkg::YW'(ye);
    r.fill_color = c;
    r.last_rect  = last;
    return r;
  endfunction

  // Advance the pixel total and queue the fill rectangles of one run
  task automatic compute_run_rects(input logic first, input logic [rrf_pkg::COLW-1:0] c,
                                   input logic [rrf_pkg::RUNW-1:0] len);
    int unsigned w, tot, col, row, pc, pr;
    if (first) begin
      pix_total = '0;
      prev_col  = '0;
      prev_row  = '0;
    end
    pix_total = pix_total + COUNT_BITS'(len);
    tot = pix_total;
    // zero width acts as one, oversize widths clamp to the panel maximum
    w = model_width;
    if (w == 0) w = 1;
    if (w > rrf_pkg::MAX_WIDTH) w = rrf_pkg::MAX_WIDTH;
    col = tot % w;
    row = tot / w + model_origin;
    if (row > rrf_pkg::MAX_ROW) row = rrf_pkg::MAX_ROW;
    pc = prev_col;
    pr = prev_row;
    if (row > pr + 1) begin
      pending_rects.push_back(make_rect(pc, pr, w - 1, pr, c, 1'b0));
      pending_rects.push_back(make_rect(0, pr + 1, w - 1, row - 1, c, 1'b0));
      pending_rects.push_back(make_rect(0, row, col, row, c, 1'b1));
    end else if (row == pr + 1) begin
      pending_rects.push_back(make_rect(pc, pr, w - 1, row - 1, c, 1'b0));
      pending_rects.push_back(make_rect(0, row, col, row, c, 1'b1));
    end else begin
      // same row or backwards: a single rectangle, taken as is
      pending_rects.push_back(make_rect(pc, pr, col, row, c, 1'b1));
    end
    prev_col = rrf_pkg::XW'(col);
    prev_row = rrf_pkg::YW'(row);
  endtask

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endtask

  task automatic queue_run(input logic first, input logic [rrf_pkg::COLW-1:0] c,
                           input logic [rrf_pkg::RUNW-1:0] len);
    run_t r;
    r.first   = first;
    r.color   = c;
    r.run_len = len;
    run_queue.push_back(r);
    runs_queued++;
  endtask

  // Wait until every queued run is taken and every rectangle has come back
  task automatic wait_idle();
    while (runs_taken != runs_queued || pending_rects.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [rrf_pkg::CFG_AW-1:0] idx,
                           input logic [rrf_pkg::CFG_DW-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    if (idx == rrf_pkg::CFG_LINE_WIDTH) model_width = data[rrf_pkg::WIDW-1:0];
    else model_origin = data[rrf_pkg::ORGW-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Run driver: bursts of transactions with random gaps in between
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (run_queue.size() != 0) begin
        drive_item = run_queue.pop_front();
        first_run  <= drive_item.first;
        color      <= drive_item.color;
        run_length <= drive_item.run_len;
        in_valid   <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output stall: random modes, plus one long hold-off to back up the input
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && rects_seen >= 100) begin
      hold_done = 1'b1;
      hold_left = 400;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 2));
        mode_left  = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= 1'b0;
      endcase
    end
  end

  // Monitor: predict on accepted runs, check accepted rectangles
  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        compute_run_rects(first_run, color, run_length);
        runs_taken++;
      end
      if (out_valid && !out_stall) begin
        rects_seen++;
        seen_rect.x_start    = x_start;
        seen_rect.y_start    = y_start;
        seen_rect.x_end      = x_end;
        seen_rect.y_end      = y_end;
        seen_rect.fill_color = fill_color;
        seen_rect.last_rect  = last_rect;
        if (pending_rects.size() == 0) begin
          flag_error($sformatf("unexpected rect xs=%0d ys=%0d xe=%0d ye=%0d col=%h last=%0d",
                               x_start, y_start, x_end, y_end, fill_color, last_rect));
        end else begin
          want_rect = pending_rects.pop_front();
          if (seen_rect !== want_rect) begin
            flag_error($sformatf({"rect mismatch: exp xs=%0d ys=%0d xe=%0d ye=%0d col=%h",
                                  " last=%0d / got xs=%0d ys=%0d xe=%0d ye=%0d col=%h last=%0d"},
                                 want_rect.x_start, want_rect.y_start, want_rect.x_end,
                                 want_rect.y_end, want_rect.fill_color, want_rect.last_rect,
                                 x_start, y_start, x_end, y_end, fill_color, last_rect));
          end
        end
      end
    end
  end

  // Stimulus phases
  initial begin
    int n;
    logic [rrf_pkg::CFG_DW-1:0] wdat;
    logic [rrf_pkg::CFG_DW-1:0] odat;
    logic [rrf_pkg::RUNW-1:0] len;
    logic fr;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset widths: zero-length after clear, exact row step, same row
    queue_run(1'b1, 16'h0000, 16'd0);
    queue_run(1'b0, 16'hFFFF, 16'hFFFF);
    queue_run(1'b0, 16'hF800, 16'd480);
    queue_run(1'b0, 16'h07E0, 16'd1);
    queue_run(1'b0, 16'h001F, 16'd0);
    queue_run(1'b1, 16'hAAAA, 16'd479);
    queue_run(1'b0, 16'h5555, 16'd1);
    wait_idle();

    // Zero width acts as one; origin after clear; row saturation
    write_reg(rrf_pkg::CFG_LINE_WIDTH, 11'd0);
    write_reg(rrf_pkg::CFG_ROW_ORIGIN, 11'd1023);
    queue_run(1'b1, 16'h1234, 16'd5);
    queue_run(1'b0, 16'h8001, 16'hFFFF);
    queue_run(1'b0, 16'h7FFE, 16'd1);
    wait_idle();

    // Oversize width clamps; first run without clear goes backwards
    write_reg(rrf_pkg::CFG_LINE_WIDTH, 11'h7FF);
    write_reg(rrf_pkg::CFG_ROW_ORIGIN, 11'd0);
    queue_run(1'b0, 16'hC3C3, 16'd0);
    queue_run(1'b1, 16'h3C3C, 16'hFFFF);
    queue_run(1'b0, 16'h0F0F, 16'd1);
    queue_run(1'b1, 16'hF0F0, 16'd1023);
    wait_idle();

    // Width one, origin bit above the register dropped
    write_reg(rrf_pkg::CFG_LINE_WIDTH, 11'd1);
    write_reg(rrf_pkg::CFG_ROW_ORIGIN, 11'h400);
    queue_run(1'b1, 16'hFFFF, 16'd2047);
    queue_run(1'b0, 16'h0000, 16'h8000);
    wait_idle();

    write_reg(rrf_pkg::CFG_LINE_WIDTH, 11'd1024);
    write_reg(rrf_pkg::CFG_ROW_ORIGIN, 11'd512);
    queue_run(1'b1, 16'h1111, 16'd1024);
    queue_run(1'b0, 16'h2222, 16'd1023);
    wait_idle();

    // Long runs until the pixel total wraps
    write_reg(rrf_pkg::CFG_LINE_WIDTH, 11'd480);
    write_reg(rrf_pkg::CFG_ROW_ORIGIN, 11'd0);
    queue_run(1'b1, 16'($urandom), 16'hFFFF);
    for (int i = 0; i < 66; i++) queue_run(1'b0, 16'($urandom), 16'hFFFF);
    wait_idle();

    // Random phases under random settings
    for (int p = 0; p < 6; p++) begin
      case ($urandom_range(0, 5))
        0:       wdat = 11'd0;
        1:       wdat = 11'd1;
        2:       wdat = 11'd1024;
        3:       wdat = 11'h7FF;
        4:       wdat = rrf_pkg::CFG_DW'($urandom_range(1, 1024));
        default: wdat = rrf_pkg::CFG_DW'($urandom_range(0, 2047));
      endcase
      case ($urandom_range(0, 2))
        0:       odat = 11'd0;
        1:       odat = 11'd1023;
        default: odat = rrf_pkg::CFG_DW'($urandom_range(0, 2047));
      endcase
      write_reg(rrf_pkg::CFG_LINE_WIDTH, wdat);
      write_reg(rrf_pkg::CFG_ROW_ORIGIN, odat);
      n = $urandom_range(18, 26);
      for (int i = 0; i < n; i++) begin
        fr = ($urandom_range(0, 9) == 0);
        case ($urandom_range(0, 9))
          0:       len = '0;
          1:       len = '1;
          2, 3:    len = rrf_pkg::RUNW'($urandom_range(1, 16));
          4, 5, 6: len = rrf_pkg::RUNW'($urandom_range(0, 2047));
          default: len = rrf_pkg::RUNW'($urandom);
        endcase
        queue_run(fr, rrf_pkg::COLW'($urandom), len);
      end
      wait_idle();
    end

    if (error_count == 0 && pending_rects.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("Run timed out");
    $display("Mismatches found");
    $finish;
  end

endmodule
